>>> hdl/kgd_pkg.sv
// Shared constants, types and control structures of the keypoint grid distributor.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package kgd_pkg;

  localparam int MAX_KEYPOINTS = 1024;
  localparam int MAX_GRID_COLS = 64;
  localparam int MAX_GRID_ROWS = 64;
  localparam int COORD_W       = 12;
  localparam int RESP_W        = 16;
  localparam int ATTR_W        = 32;
  localparam int WIN_W         = 8;
  localparam int PAD           = 3;

  localparam int IDX_W  = $clog2(MAX_KEYPOINTS);
  localparam int CNT_W  = IDX_W + 1;
  localparam int COL_W  = $clog2(MAX_GRID_COLS);
  localparam int ROW_W  = $clog2(MAX_GRID_ROWS);
  localparam int CELL_W = COL_W + ROW_W;
  localparam int KEY_W  = CELL_W + IDX_W;
  // The rounded-up cell size divides extent + count - 1, which needs two bits over a coordinate.
  localparam int DIV_W  = COORD_W + 2;
  localparam int EXT_W  = COORD_W + 2;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_X     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_X     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_Y     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_Y     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW    = 3'd5;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_FETCH = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE, S_CLEAR, S_GEO_GO, S_GEO_WAIT, S_COL_GO, S_COL_WAIT,
    S_ROW_GO, S_ROW_WAIT, S_STORE, S_SCAN, S_FETCH_RD, S_FETCH_OUT
  } state_t;

  typedef enum logic [2:0] {
    DIV_NCOLS, DIV_WCELL, DIV_NROWS, DIV_HCELL, DIV_COL, DIV_ROW
  } div_sel_t;

  typedef struct packed {
    logic              valid;
    logic              is_strong;
    logic [CELL_W-1:0] cell_id;
  } tag_t;

  typedef struct packed {
    logic             take;
    logic             end_frame;
    logic             set_drain;
    logic             clr_en;
    logic [COL_W-1:0] clr_row;
    logic             div_start;
    div_sel_t         div_sel;
    logic             geo_write;
    logic             col_write;
    logic             row_write;
    logic             store;
    logic             scan_start;
    logic             scan_run;
    logic             out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic draining;
    logic count_zero;
    logic count_full;
    logic div_done;
    logic scan_done;
    logic out_full;
  } dp_status_t;

endpackage

`default_nettype wire

>>> hdl/kgd_in_if.sv
// Input channel of the keypoint grid distributor: valid/ready plus one keypoint command.
// Depends on kgd_pkg for field widths.
`default_nettype none

interface kgd_in_if import kgd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               cmd;
  logic [COORD_W-1:0] key_x;
  logic [COORD_W-1:0] key_y;
  logic [RESP_W-1:0]  key_response;
  logic [ATTR_W-1:0]  key_attrs;

  modport source (output valid, cmd, key_x, key_y, key_response, key_attrs, input ready);
  modport sink   (input valid, cmd, key_x, key_y, key_response, key_attrs, output ready);
endinterface

`default_nettype wire

>>> hdl/kgd_out_if.sv
// Output channel of the keypoint grid distributor: valid/ready plus one fetch result.
// Depends on kgd_pkg for field widths.
`default_nettype none

interface kgd_out_if import kgd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               out_valid;
  logic [COORD_W-1:0] out_x;
  logic [COORD_W-1:0] out_y;
  logic [RESP_W-1:0]  out_response;
  logic [ATTR_W-1:0]  out_attrs;
  logic               out_last;

  modport source (output valid, out_valid, out_x, out_y, out_response, out_attrs, out_last,
                  input ready);
  modport sink   (input valid, out_valid, out_x, out_y, out_response, out_attrs, out_last,
                  output ready);
endinterface

`default_nettype wire

>>> hdl/kgd_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// Depends on kgd_pkg for DIV_W.
`default_nettype none

module kgd_div import kgd_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [DIV_W-1:0] divisor,
  output logic             done,
  output logic [DIV_W-1:0] quotient
);

  localparam int CNT_BITS = $clog2(DIV_W + 1);

  logic [DIV_W-1:0]    rem;
  logic [DIV_W-1:0]    dvs;
  logic [CNT_BITS-1:0] cnt;
  logic [DIV_W:0]      shifted;
  logic                ge;

  assign shifted = {rem, quotient[DIV_W-1]};
  assign ge      = shifted >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= (cnt == CNT_BITS'(1));
      if (start) begin
        cnt <= CNT_BITS'(DIV_W);
      end else if (cnt != '0) begin
        cnt <= cnt - CNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      dvs      <= divisor;
    end else if (cnt != '0) begin
      quotient <= {quotient[DIV_W-2:0], ge};
      rem      <= ge ? DIV_W'(shifted - {1'b0, dvs}) : shifted[DIV_W-1:0];
    end
  end

endmodule

`default_nettype wire

>>> hdl/kgd_datapath.sv
// Datapath: configuration registers, keypoint stores, strong-cell map, cell geometry,
// drain scan pipeline and output register. Depends on kgd_pkg and kgd_div.
`default_nettype none

module kgd_datapath import kgd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [COORD_W-1:0]    key_x,
  input  logic [COORD_W-1:0]    key_y,
  input  logic [RESP_W-1:0]     key_response,
  input  logic [ATTR_W-1:0]     key_attrs,
  input  ctrl_cmd_t             cmd,
  output dp_status_t            st,
  input  logic                  out_ready,
  output logic                  out_full,
  output logic                  out_valid,
  output logic [COORD_W-1:0]    out_x,
  output logic [COORD_W-1:0]    out_y,
  output logic [RESP_W-1:0]     out_response,
  output logic [ATTR_W-1:0]     out_attrs,
  output logic                  out_last
);

  // Configuration
  logic [RESP_W-1:0]  thr;
  logic [COORD_W-1:0] min_x, max_x, min_y, max_y;
  logic [WIN_W-1:0]   window;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr    <= RESP_W'(20);
      min_x  <= '0;
      max_x  <= '1;
      min_y  <= '0;
      max_y  <= '1;
      window <= WIN_W'(30);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_THRESHOLD: thr    <= cfg_data[RESP_W-1:0];
        REG_MIN_X:     min_x  <= cfg_data[COORD_W-1:0];
        REG_MAX_X:     max_x  <= cfg_data[COORD_W-1:0];
        REG_MIN_Y:     min_y  <= cfg_data[COORD_W-1:0];
        REG_MAX_Y:     max_y  <= cfg_data[COORD_W-1:0];
        REG_WINDOW:    window <= cfg_data[WIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Captured keypoint
  logic [COORD_W-1:0] kx, ky;
  logic [RESP_W-1:0]  kr;
  logic [ATTR_W-1:0]  ka;

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      kx <= key_x;
      ky <= key_y;
      kr <= key_response;
      ka <= key_attrs;
    end
  end

  // Geometry and divider operands
  logic [DIV_W-1:0] ncols, wcell, nrows, hcell, col_q, row_q;
  logic [DIV_W-1:0] dvd, dvs, div_q;
  logic             div_done;
  logic             geo_ok;
  logic [EXT_W-1:0] ext_x, ext_y;
  logic             ext_x_pos, ext_y_pos;

  assign ext_x = EXT_W'({2'b00, max_x} - {2'b00, min_x} + EXT_W'(2 * PAD));
  assign ext_y = EXT_W'({2'b00, max_y} - {2'b00, min_y} + EXT_W'(2 * PAD));
  assign ext_x_pos = !ext_x[EXT_W-1] && (ext_x != '0);
  assign ext_y_pos = !ext_y[EXT_W-1] && (ext_y != '0);

  always_comb begin
    dvd    = '0;
    dvs    = '0;
    geo_ok = 1'b0;
    unique case (cmd.div_sel)
      DIV_NCOLS: begin
        dvd    = ext_x[DIV_W-1:0];
        dvs    = DIV_W'(window);
        geo_ok = ext_x_pos && (window != '0);
      end
      DIV_WCELL: begin
        dvd    = DIV_W'(ext_x[DIV_W-1:0] + ncols - DIV_W'(1));
        dvs    = ncols;
        geo_ok = ncols != '0;
      end
      DIV_NROWS: begin
        dvd    = ext_y[DIV_W-1:0];
        dvs    = DIV_W'(window);
        geo_ok = ext_y_pos && (window != '0);
      end
      DIV_HCELL: begin
        dvd    = DIV_W'(ext_y[DIV_W-1:0] + nrows - DIV_W'(1));
        dvs    = nrows;
        geo_ok = nrows != '0;
      end
      DIV_COL: begin
        dvd = DIV_W'(COORD_W'(kx - min_x));
        dvs = wcell;
      end
      DIV_ROW: begin
        dvd = DIV_W'(COORD_W'(ky - min_y));
        dvs = hcell;
      end
      default: ;
    endcase
  end

  kgd_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (dvd),
    .divisor  (dvs),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ncols <= '0;
      wcell <= '0;
      nrows <= '0;
      hcell <= '0;
    end else if (cmd.geo_write) begin
      unique case (cmd.div_sel)
        DIV_NCOLS: ncols <= geo_ok ? div_q : '0;
        DIV_WCELL: wcell <= geo_ok ? div_q : '0;
        DIV_NROWS: nrows <= geo_ok ? div_q : '0;
        DIV_HCELL: hcell <= geo_ok ? div_q : '0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.col_write) col_q <= div_q;
    if (cmd.row_write) row_q <= div_q;
  end

  // Tag of the keypoint being loaded
  tag_t new_tag;
  logic in_range;

  assign in_range = (ncols != '0) && (nrows != '0)
                 && (kx >= min_x) && (kx < max_x) && (ky >= min_y) && (ky < max_y)
                 && (col_q < ncols) && (row_q < nrows)
                 && (col_q < DIV_W'(MAX_GRID_COLS)) && (row_q < DIV_W'(MAX_GRID_ROWS));

  always_comb begin
    new_tag = '0;
    if (in_range) begin
      new_tag.valid     = 1'b1;
      new_tag.is_strong = kr >= thr;
      new_tag.cell_id   = {col_q[COL_W-1:0], row_q[ROW_W-1:0]};
    end
  end

  // Frame state
  logic [CNT_W-1:0] count;
  logic             draining;
  logic [KEY_W-1:0] cursor;
  logic [KEY_W-1:0] best_key;
  logic             have_best, have_next;
  logic             last_n;

  assign last_n = !have_best || !have_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      draining <= 1'b0;
      cursor   <= '0;
    end else begin
      if (cmd.end_frame || (cmd.out_load && last_n)) begin
        count    <= '0;
        draining <= 1'b0;
      end else if (cmd.store) begin
        count <= count + CNT_W'(1);
      end
      if (cmd.set_drain) begin
        draining <= 1'b1;
        cursor   <= '0;
      end else if (cmd.out_load && !last_n) begin
        cursor <= best_key + KEY_W'(1);
      end
    end
  end

  // Keypoint stores
  logic [2*COORD_W-1:0] pos_mem  [MAX_KEYPOINTS];
  logic [RESP_W-1:0]    resp_mem [MAX_KEYPOINTS];
  logic [ATTR_W-1:0]    attr_mem [MAX_KEYPOINTS];
  tag_t                 tag_mem  [MAX_KEYPOINTS];
  logic [2*COORD_W-1:0] pos_q;
  logic [RESP_W-1:0]    resp_q;
  logic [ATTR_W-1:0]    attr_q;

  logic [CNT_W-1:0] scan_addr;
  tag_t             tag_q, tag2;
  logic [IDX_W-1:0] idx1, idx2;
  logic             v1, v2;
  logic             issue;

  assign issue = cmd.scan_run && (scan_addr < count);

  always_ff @(posedge clk) begin
    if (cmd.store) begin
      pos_mem[count[IDX_W-1:0]]  <= {ky, kx};
      resp_mem[count[IDX_W-1:0]] <= kr;
      attr_mem[count[IDX_W-1:0]] <= ka;
      tag_mem[count[IDX_W-1:0]]  <= new_tag;
    end
    tag_q  <= tag_mem[scan_addr[IDX_W-1:0]];
    pos_q  <= pos_mem[best_key[IDX_W-1:0]];
    resp_q <= resp_mem[best_key[IDX_W-1:0]];
    attr_q <= attr_mem[best_key[IDX_W-1:0]];
  end

  // Strong-cell map: one row per grid column, one bit per grid row.
  logic [MAX_GRID_ROWS-1:0] strong_map [MAX_GRID_COLS];
  logic [MAX_GRID_ROWS-1:0] map_q;

  always_ff @(posedge clk) begin
    if (cmd.clr_en) begin
      strong_map[cmd.clr_row] <= '0;
    end else if (cmd.store && new_tag.valid && new_tag.is_strong) begin
      strong_map[col_q[COL_W-1:0]][row_q[ROW_W-1:0]] <= 1'b1;
    end
    map_q <= strong_map[tag_q.cell_id[CELL_W-1:ROW_W]];
  end

  // Drain scan: tag read, map read, then compare against the cursor.
  logic             kept, cand;
  logic [KEY_W-1:0] key2;

  assign key2 = {tag2.cell_id, idx2};
  assign kept = tag2.valid && (tag2.is_strong || !map_q[tag2.cell_id[ROW_W-1:0]]);
  assign cand = v2 && kept && (key2 >= cursor);

  always_ff @(posedge clk) begin
    idx1 <= scan_addr[IDX_W-1:0];
    tag2 <= tag_q;
    idx2 <= idx1;
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.scan_start) begin
      scan_addr <= '0;
      v1        <= 1'b0;
      v2        <= 1'b0;
      have_best <= 1'b0;
      have_next <= 1'b0;
    end else begin
      v1 <= issue;
      v2 <= v1;
      if (issue) scan_addr <= scan_addr + CNT_W'(1);
      if (cand) begin
        if (!have_best || key2 < best_key) begin
          best_key  <= key2;
          have_best <= 1'b1;
          have_next <= have_best;
        end else begin
          have_next <= 1'b1;
        end
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (cmd.out_load) begin
      out_full <= 1'b1;
    end else if (out_ready) begin
      out_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_valid    <= have_best;
      out_x        <= have_best ? pos_q[COORD_W-1:0] : '0;
      out_y        <= have_best ? pos_q[2*COORD_W-1:COORD_W] : '0;
      out_response <= have_best ? resp_q : '0;
      out_attrs    <= have_best ? attr_q : '0;
      out_last     <= last_n;
    end
  end

  assign st.draining   = draining;
  assign st.count_zero = count == '0;
  assign st.count_full = count >= CNT_W'(MAX_KEYPOINTS);
  assign st.div_done   = div_done;
  assign st.scan_done  = !((scan_addr < count) || v1 || v2);
  assign st.out_full   = out_full;

endmodule

`default_nettype wire

>>> hdl/kgd_ctrl.sv
// Controller state machine: sequences map clearing, geometry and binning divisions,
// stores, and the drain scan. Depends on kgd_pkg.
`default_nettype none

module kgd_ctrl import kgd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_cmd,
  input  dp_status_t st,
  output logic       in_ready,
  output ctrl_cmd_t  cmd
);

  state_t           state, state_next;
  logic [1:0]       geo_step;
  logic [COL_W-1:0] clr_cnt;
  logic             accept;
  div_sel_t         geo_sel;

  assign in_ready = (state == S_IDLE) && !st.out_full;
  assign accept   = in_ready && in_valid;

  always_comb begin
    unique case (geo_step)
      2'd0: geo_sel = DIV_NCOLS;
      2'd1: geo_sel = DIV_WCELL;
      2'd2: geo_sel = DIV_NROWS;
      2'd3: geo_sel = DIV_HCELL;
      default: geo_sel = DIV_NCOLS;
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (in_cmd == CMD_FETCH) begin
            state_next = S_SCAN;
          end else if (st.draining || st.count_zero) begin
            state_next = S_CLEAR;
          end else if (!st.count_full) begin
            state_next = S_COL_GO;
          end
        end
      end
      S_CLEAR:     if (clr_cnt == COL_W'(MAX_GRID_COLS - 1)) state_next = S_GEO_GO;
      S_GEO_GO:    state_next = S_GEO_WAIT;
      S_GEO_WAIT:  if (st.div_done) state_next = (geo_step == 2'd3) ? S_COL_GO : S_GEO_GO;
      S_COL_GO:    state_next = S_COL_WAIT;
      S_COL_WAIT:  if (st.div_done) state_next = S_ROW_GO;
      S_ROW_GO:    state_next = S_ROW_WAIT;
      S_ROW_WAIT:  if (st.div_done) state_next = S_STORE;
      S_STORE:     state_next = S_IDLE;
      S_SCAN:      if (st.scan_done) state_next = S_FETCH_RD;
      S_FETCH_RD:  state_next = S_FETCH_OUT;
      S_FETCH_OUT: state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd         = '0;
    cmd.div_sel = DIV_COL;
    unique case (state)
      S_IDLE: begin
        cmd.take       = accept;
        cmd.end_frame  = accept && (in_cmd == CMD_LOAD) && st.draining;
        cmd.set_drain  = accept && (in_cmd == CMD_FETCH) && !st.draining;
        cmd.scan_start = accept && (in_cmd == CMD_FETCH);
      end
      S_CLEAR: begin
        cmd.clr_en  = 1'b1;
        cmd.clr_row = clr_cnt;
      end
      S_GEO_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = geo_sel;
      end
      S_GEO_WAIT: begin
        cmd.div_sel   = geo_sel;
        cmd.geo_write = st.div_done;
      end
      S_COL_GO:   cmd.div_start = 1'b1;
      S_COL_WAIT: cmd.col_write = st.div_done;
      S_ROW_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_ROW;
      end
      S_ROW_WAIT: begin
        cmd.div_sel   = DIV_ROW;
        cmd.row_write = st.div_done;
      end
      S_STORE:     cmd.store    = 1'b1;
      S_SCAN:      cmd.scan_run = 1'b1;
      S_FETCH_RD:  ;
      S_FETCH_OUT: cmd.out_load = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      geo_step <= '0;
      clr_cnt  <= '0;
    end else begin
      state <= state_next;
      if (state == S_IDLE) begin
        geo_step <= '0;
        clr_cnt  <= '0;
      end else begin
        if (state == S_CLEAR) clr_cnt <= clr_cnt + COL_W'(1);
        if (state == S_GEO_WAIT && st.div_done) geo_step <= geo_step + 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

>>> hdl/keypoint_grid_distributor.sv
// Keypoint grid distributor, top level: controller plus datapath.
// Depends on kgd_pkg, kgd_in_if, kgd_out_if, kgd_ctrl and kgd_datapath.
`default_nettype none

// Loads a frame's keypoints (cmd 0) and returns the kept ones one per fetch (cmd 1) in
// column-major cell order. The first load of a frame clears the 64-row strong-cell map
// and computes the grid with four divisions; every load then bins its keypoint with two
// passes through the shared 14-bit serial divider before the store. A fetch scans all
// stored keypoints through a three-stage read pipeline before its result is registered.
// One transaction is in flight at a time, and a new one is taken only once the output
// register is empty.

module keypoint_grid_distributor import kgd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  kgd_in_if.sink                in_ch,
  kgd_out_if.source             out_ch
);

  ctrl_cmd_t  cmd;
  dp_status_t st;

  kgd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_cmd   (in_ch.cmd),
    .st       (st),
    .in_ready (in_ch.ready),
    .cmd      (cmd)
  );

  kgd_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .key_x        (in_ch.key_x),
    .key_y        (in_ch.key_y),
    .key_response (in_ch.key_response),
    .key_attrs    (in_ch.key_attrs),
    .cmd          (cmd),
    .st           (st),
    .out_ready    (out_ch.ready),
    .out_full     (out_ch.valid),
    .out_valid    (out_ch.out_valid),
    .out_x        (out_ch.out_x),
    .out_y        (out_ch.out_y),
    .out_response (out_ch.out_response),
    .out_attrs    (out_ch.out_attrs),
    .out_last     (out_ch.out_last)
  );

  // A new transaction is never taken while a result is still waiting.
  a_ready_excl: assert property (@(posedge clk) disable iff (rst)
    in_ch.ready |-> !out_ch.valid)
    else $error("input ready while a result is pending");

  // A fetch always goes through the scan before anything else is taken.
  a_fetch_busy: assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ch.ready && in_ch.cmd == CMD_FETCH) |=> !in_ch.ready)
    else $error("input ready right after a fetch");

  // An empty fetch result ends the frame and carries zero payload.
  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && !out_ch.out_valid) |-> (out_ch.out_last && out_ch.out_x == '0
                                             && out_ch.out_attrs == '0))
    else $error("empty result without last flag or with nonzero payload");

endmodule

`default_nettype wire

>>> sim/kgd_grid_checker.sv
// Checker for the keypoint grid distributor: watches the configuration port and both
// channels, keeps its own model of the grid filter and compares every fetch result.
// Depends on kgd_pkg, kgd_in_if and kgd_out_if.
`timescale 1ns / 1ps

module kgd_grid_checker import kgd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  kgd_in_if                     in_ch,
  kgd_out_if                    out_ch,
  output int                    failures,
  output int                    pending
);

  typedef struct packed {
    logic               found;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [RESP_W-1:0]  resp;
    logic [ATTR_W-1:0]  attrs;
    logic               last;
  } kept_point_t;

  logic [RESP_W-1:0]  threshold;
  logic [COORD_W-1:0] min_x, max_x, min_y, max_y;
  logic [WIN_W-1:0]   window;

  logic [COORD_W-1:0] pt_x [MAX_KEYPOINTS];
  logic [COORD_W-1:0] pt_y [MAX_KEYPOINTS];
  logic [RESP_W-1:0]  pt_resp [MAX_KEYPOINTS];
  logic [ATTR_W-1:0]  pt_attrs [MAX_KEYPOINTS];
  bit                 pt_binned [MAX_KEYPOINTS];
  bit                 pt_strong [MAX_KEYPOINTS];
  int                 pt_cell [MAX_KEYPOINTS];
  bit                 cell_has_strong [MAX_GRID_COLS*MAX_GRID_ROWS];

  int n_loaded, drain_cell, drain_scan;
  bit draining, have_cells;
  int ncols, nrows, wcell, hcell;

  kept_point_t fetch_results [$];

  function automatic void axis_grid(input int lo, input int hi, output int count,
                                    output int size);
    int extent;
    extent = hi - lo + 2 * PAD;
    count = 0;
    size = 0;
    if (window != 0 && extent > 0) begin
      count = extent / int'(window);
      if (count > 0) size = (extent + count - 1) / count;
    end
  endfunction

  function automatic void load_point(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                                     input logic [RESP_W-1:0] r, input logic [ATTR_W-1:0] a);
    int col, row;
    bit is_strong;
    if (draining) begin
      n_loaded = 0;
      draining = 0;
    end
    if (n_loaded == 0) begin
      foreach (cell_has_strong[i]) cell_has_strong[i] = 0;
      axis_grid(min_x, max_x, ncols, wcell);
      axis_grid(min_y, max_y, nrows, hcell);
      have_cells = ncols > 0 && nrows > 0;
    end
    if (n_loaded >= MAX_KEYPOINTS) return;
    is_strong = r >= threshold;
    pt_binned[n_loaded] = 0;
    pt_cell[n_loaded] = 0;
    if (have_cells && x >= min_x && x < max_x && y >= min_y && y < max_y) begin
      col = (x - min_x) / wcell;
      row = (y - min_y) / hcell;
      if (col < ncols && row < nrows && col < MAX_GRID_COLS && row < MAX_GRID_ROWS) begin
        pt_binned[n_loaded] = 1;
        pt_cell[n_loaded] = col * MAX_GRID_ROWS + row;
        if (is_strong) cell_has_strong[pt_cell[n_loaded]] = 1;
      end
    end
    pt_strong[n_loaded] = is_strong;
    pt_x[n_loaded] = x;
    pt_y[n_loaded] = y;
    pt_resp[n_loaded] = r;
    pt_attrs[n_loaded] = a;
    n_loaded++;
  endfunction

  // Points are ordered by cell, then by load order; the cursor marks the position just after
  // the last returned point.
  function automatic kept_point_t fetch_point();
    kept_point_t res;
    longint cursor, best, second, key;
    int bi;
    res = '0;
    best = -1;
    second = -1;
    bi = 0;
    if (!draining) begin
      draining = 1;
      drain_cell = 0;
      drain_scan = 0;
    end
    cursor = longint'(drain_cell) * MAX_KEYPOINTS + drain_scan;
    for (int i = 0; i < n_loaded; i++) begin
      if (!pt_binned[i]) continue;
      if (!pt_strong[i] && cell_has_strong[pt_cell[i]]) continue;
      key = longint'(pt_cell[i]) * MAX_KEYPOINTS + i;
      if (key < cursor) continue;
      if (best < 0 || key < best) begin
        second = best;
        best = key;
        bi = i;
      end else if (second < 0 || key < second) begin
        second = key;
      end
    end
    if (best < 0) begin
      res.last = 1;
      n_loaded = 0;
      draining = 0;
      return res;
    end
    res.found = 1;
    res.x = pt_x[bi];
    res.y = pt_y[bi];
    res.resp = pt_resp[bi];
    res.attrs = pt_attrs[bi];
    if (second < 0) begin
      res.last = 1;
      n_loaded = 0;
      draining = 0;
    end else begin
      drain_cell = pt_cell[bi];
      drain_scan = bi + 1;
    end
    return res;
  endfunction

  always @(posedge clk) begin
    kept_point_t want, got;
    if (rst) begin
      threshold = RESP_W'(20);
      min_x = '0;
      max_x = '1;
      min_y = '0;
      max_y = '1;
      window = WIN_W'(30);
      n_loaded = 0;
      draining = 0;
      drain_cell = 0;
      drain_scan = 0;
      failures = 0;
      fetch_results.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_THRESHOLD: threshold = cfg_data;
          REG_MIN_X:     min_x = cfg_data[COORD_W-1:0];
          REG_MAX_X:     max_x = cfg_data[COORD_W-1:0];
          REG_MIN_Y:     min_y = cfg_data[COORD_W-1:0];
          REG_MAX_Y:     max_y = cfg_data[COORD_W-1:0];
          REG_WINDOW:    window = cfg_data[WIN_W-1:0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.cmd == CMD_LOAD) begin
          load_point(in_ch.key_x, in_ch.key_y, in_ch.key_response, in_ch.key_attrs);
        end else begin
          got = fetch_point();
          fetch_results = {fetch_results, got};
        end
      end
      if (out_ch.valid && out_ch.ready) begin
        if (fetch_results.size() == 0) begin
          $display("%0t: result with none expected: out_valid %0b x %0d y %0d", $time,
                   out_ch.out_valid, out_ch.out_x, out_ch.out_y);
          failures++;
        end else begin
          want = fetch_results.pop_front();
          if (out_ch.out_valid !== want.found) begin
            $display("%0t: out_valid expected %0b actual %0b", $time, want.found,
                     out_ch.out_valid);
            failures++;
          end
          if (out_ch.out_x !== want.x) begin
            $display("%0t: out_x expected %0d actual %0d", $time, want.x, out_ch.out_x);
            failures++;
          end
          if (out_ch.out_y !== want.y) begin
            $display("%0t: out_y expected %0d actual %0d", $time, want.y, out_ch.out_y);
            failures++;
          end
          if (out_ch.out_response !== want.resp) begin
            $display("%0t: out_response expected %0d actual %0d", $time, want.resp,
                     out_ch.out_response);
            failures++;
          end
          if (out_ch.out_attrs !== want.attrs) begin
            $display("%0t: out_attrs expected %h actual %h", $time, want.attrs,
                     out_ch.out_attrs);
            failures++;
          end
          if (out_ch.out_last !== want.last) begin
            $display("%0t: out_last expected %0b actual %0b", $time, want.last,
                     out_ch.out_last);
            failures++;
          end
        end
      end
    end
    pending = fetch_results.size();
  end

endmodule

>>> sim/tb_keypoint_grid_distributor.sv
// Top of the keypoint grid distributor testbench: clock, reset, register writes, keypoint
// frames with random gaps and output stalls. Depends on kgd_pkg, both channel
// interfaces, the block itself and kgd_grid_checker.
`timescale 1ns / 1ps

module tb_keypoint_grid_distributor;
  import kgd_pkg::*;

  logic                  clk = 0;
  logic                  rst = 1;
  logic                  cfg_we = 0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int                    failures, pending;
  int                    sent_items = 0;
  bit                    src_gaps = 1, sink_stalls = 1, stim_done = 0;
  logic [COORD_W-1:0]    cur_min_x = 0, cur_max_x = 4095, cur_min_y = 0, cur_max_y = 4095;
  logic [RESP_W-1:0]     cur_threshold = 20;

  kgd_in_if  in_ch ();
  kgd_out_if out_ch ();

  keypoint_grid_distributor u_top (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data, .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  kgd_grid_checker u_checker (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data, .in_ch(in_ch), .out_ch(out_ch),
    .failures, .pending
  );

  always #10 clk = ~clk;

  initial begin
    in_ch.valid = 0;
    in_ch.cmd = CMD_LOAD;
    in_ch.key_x = '0;
    in_ch.key_y = '0;
    in_ch.key_response = '0;
    in_ch.key_attrs = '0;
    out_ch.ready = 0;
  end

  // Result side: a random stall before each transaction unless stalls are off.
  always begin
    int stall;
    @(posedge clk);
    stall = sink_stalls ? $urandom_range(0, 19) : 0;
    if (stall > 0) begin
      out_ch.ready <= 0;
      repeat (stall) @(posedge clk);
    end
    out_ch.ready <= 1;
    do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
  end

  task automatic send(input logic cmd, input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                      input logic [RESP_W-1:0] r, input logic [ATTR_W-1:0] a);
    int gap;
    gap = src_gaps ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      in_ch.valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1;
    in_ch.cmd <= cmd;
    in_ch.key_x <= x;
    in_ch.key_y <= y;
    in_ch.key_response <= r;
    in_ch.key_attrs <= a;
    do @(posedge clk); while (!in_ch.ready);
    sent_items++;
  endtask

  task automatic load(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                      input logic [RESP_W-1:0] r);
    send(CMD_LOAD, x, y, r, $urandom);
  endtask

  task automatic fetch();
    send(CMD_FETCH, COORD_W'($urandom), COORD_W'($urandom), RESP_W'($urandom), $urandom);
  endtask

  // A load can still be at work when the last result is in, so allow for a full load.
  task automatic wait_idle();
    in_ch.valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic set_config(input logic [RESP_W-1:0] thr, input logic [COORD_W-1:0] x0,
                            input logic [COORD_W-1:0] x1, input logic [COORD_W-1:0] y0,
                            input logic [COORD_W-1:0] y1, input logic [WIN_W-1:0] win);
    logic [CFG_DATA_W-1:0] vals [6];
    logic [CFG_IDX_W-1:0]  idxs [6];
    vals = '{thr, 16'(x0), 16'(x1), 16'(y0), 16'(y1), 16'(win)};
    idxs = '{REG_THRESHOLD, REG_MIN_X, REG_MAX_X, REG_MIN_Y, REG_MAX_Y, REG_WINDOW};
    wait_idle();
    for (int i = 0; i < 6; i++) begin
      cfg_we <= 1;
      cfg_index <= idxs[i];
      cfg_data <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 0;
    cur_threshold = thr;
    cur_min_x = x0;
    cur_max_x = x1;
    cur_min_y = y0;
    cur_max_y = y1;
  endtask

  function automatic logic [COORD_W-1:0] pick_coord(input logic [COORD_W-1:0] lo,
                                                    input logic [COORD_W-1:0] hi);
    if (hi > lo && $urandom_range(0, 9) < 8) return COORD_W'($urandom_range(lo, hi - 1));
    return COORD_W'($urandom);
  endfunction

  function automatic logic [RESP_W-1:0] pick_response();
    int top;
    top = int'(cur_threshold) * 2 + 2;
    if (top > 65535) top = 65535;
    if ($urandom_range(0, 3) != 0) return RESP_W'($urandom_range(0, top));
    return RESP_W'($urandom);
  endfunction

  task automatic random_frame(input int n_loads, input int n_fetches);
    for (int i = 0; i < n_loads; i++)
      load(pick_coord(cur_min_x, cur_max_x), pick_coord(cur_min_y, cur_max_y), pick_response());
    for (int i = 0; i < n_fetches; i++) begin
      // Now and then a load breaks into the drain and starts a new frame.
      if ($urandom_range(0, 99) == 0) return;
      fetch();
    end
  endtask

  initial begin
    int w, x0, y0, n;
    repeat (12) @(posedge clk);
    rst <= 0;

    // Directed: reset registers, field extremes and the threshold boundary.
    fetch();
    load(0, 0, 0);
    send(CMD_LOAD, 12'hFFF, 12'hFFF, 16'hFFFF, 32'hFFFF_FFFF);
    load(40, 40, 19);
    load(45, 41, 20);
    load(100, 10, 3);
    load(101, 11, 4);
    load(4094, 4094, 16'hFFFF);
    repeat (5) fetch();
    fetch();
    load(2000, 2000, 500);
    load(2001, 2001, 5);
    fetch();
    load(10, 10, 1);
    repeat (3) fetch();
    // No cells: inverted region, then a region narrower than one window.
    set_config(16'hFFFF, 12'hFFF, 0, 0, 12'hFFF, 8'hFF);
    load(100, 100, 16'hFFFF);
    fetch();
    set_config(0, 100, 110, 100, 110, 8'd30);
    load(105, 105, 0);
    fetch();
    // A window of 8 over the whole area: far more columns than the grid holds.
    set_config(100, 0, 12'hFFF, 0, 12'hFFF, 8'd8);
    load(4000, 10, 200);
    load(10, 4000, 200);
    load(300, 300, 50);
    repeat (3) fetch();

    // One frame that overflows the keypoint store, drained only in part.
    set_config(1000, 0, 12'hFFF, 0, 12'hFFF, 8'd255);
    random_frame(MAX_KEYPOINTS + 6, 4);

    while (sent_items < 2000) begin
      src_gaps = $urandom_range(0, 3) != 0;
      sink_stalls = $urandom_range(0, 3) != 0;
      w = $urandom_range(8, 60);
      case ($urandom_range(0, 5))
        0: set_config(RESP_W'($urandom), 0, 12'hFFF, 0, 12'hFFF,
                      WIN_W'($urandom_range(8, 255)));
        1: set_config(RESP_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
                      COORD_W'($urandom), COORD_W'($urandom), WIN_W'($urandom));
        default: begin
          x0 = $urandom_range(0, 3800);
          y0 = $urandom_range(0, 3800);
          set_config(RESP_W'($urandom_range(0, 1) ? $urandom_range(0, 300) : $urandom),
                     COORD_W'(x0), COORD_W'(x0 + $urandom_range(0, 4 * w)),
                     COORD_W'(y0), COORD_W'(y0 + $urandom_range(0, 4 * w)), WIN_W'(w));
        end
      endcase
      for (int f = 0; f < 3; f++) begin
        n = $urandom_range(0, 30);
        random_frame(n, $urandom_range(0, 4) == 0 ? $urandom_range(0, n) : n + 2);
      end
    end

    in_ch.valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    stim_done = 1;
    if (failures == 0)
      $display("keypoint_grid_distributor: match");
    else
      $display("keypoint_grid_distributor: mismatch");
    $finish;
  end

  initial begin
    #200ms;
    if (!stim_done) $display("keypoint_grid_distributor: mismatch");
    $finish;
  end

endmodule
